### design/fack_pkg.sv
package fack_pkg;

   localparam int unsigned NumRounds = 10;
   localparam int unsigned NumBytes  = 16;

   localparam logic [1:0] CsrKeyLow  = 2'd0;
   localparam logic [1:0] CsrKeyHigh = 2'd1;

   // counter block bytes 0..11, byte 0 in bits 7:0
   localparam logic [95:0] Nonce = 96'h616c6663_6e657477_656e796d;

   typedef logic [127:0] block_type;

   typedef struct packed {
      logic       range_err;
      logic [3:0] offset;
      logic [4:0] count;
      block_type  data;
   } side_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] RCON [10] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // one round: subbytes, shiftrows, optional mixcolumns, add round key
   function automatic block_type aes_round(input block_type s, input block_type rk,
                                           input logic last);
      block_type  t;
      logic [7:0] a0, a1, a2, a3, al;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
         end
      end
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[8*(4*c) +: 8];
            a1 = t[8*(4*c+1) +: 8];
            a2 = t[8*(4*c+2) +: 8];
            a3 = t[8*(4*c+3) +: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[8*(4*c) +: 8]   = a0 ^ al ^ xtime(a0 ^ a1);
            t[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      return t ^ rk;
   endfunction

   // next round key from the previous one
   function automatic block_type next_key(input block_type k, input logic [7:0] rc);
      block_type  n;
      logic [31:0] w;
      w = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]],
           SBOX[k[111:104]] ^ rc};
      n[31:0]   = k[31:0] ^ w;
      n[63:32]  = k[63:32] ^ n[31:0];
      n[95:64]  = k[95:64] ^ n[63:32];
      n[127:96] = k[127:96] ^ n[95:64];
      return n;
   endfunction

endpackage

### design/fack_key_sched.sv
module fack_key_sched (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [63:0]         csr_write_data,
   output fack_pkg::block_type round_keys [11]
);
   import fack_pkg::*;

   block_type key_ff;
   // rk_ff[r] holds the key of round r+1
   block_type rk_ff [10];
   block_type rk_in [10];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrKeyLow:  key_ff[63:0]   <= csr_write_data;
            CsrKeyHigh: key_ff[127:64] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // expansion ripples one round key per cycle, staying one step ahead of a beat
   always_comb begin
      rk_in[0] = next_key(key_ff, RCON[0]);
      for (int r = 1; r < NumRounds; r++) begin
         rk_in[r] = next_key(rk_ff[r-1], RCON[r]);
      end
   end

   always_ff @(posedge clock) begin
      rk_ff <= rk_in;
   end

   always_comb begin
      round_keys[0] = key_ff;
      for (int r = 1; r <= NumRounds; r++) begin
         round_keys[r] = rk_ff[r-1];
      end
   end
endmodule

### design/fack_round_pipe.sv
module fack_round_pipe (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  fack_pkg::block_type in_block,
   input  fack_pkg::side_type  in_side,
   input  fack_pkg::block_type round_keys [11],
   output logic                out_valid,
   output fack_pkg::block_type out_block,
   output fack_pkg::side_type  out_side
);
   import fack_pkg::*;

   logic      valid_ff [11];
   block_type st_ff    [11];
   side_type  side_ff  [11];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 11; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < 11; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff[0]   <= in_block ^ round_keys[0];
         side_ff[0] <= in_side;
         for (int i = 1; i < 11; i++) begin
            st_ff[i]   <= aes_round(st_ff[i-1], round_keys[i], i == NumRounds);
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[10];
   assign out_block = st_ff[10];
   assign out_side  = side_ff[10];
endmodule

### design/flash_aes_ctr_keystream_xor_unit.sv
// channel | valid     | ready     | payload
// req     | req_valid | req_ready | block_address byte_offset byte_count data_in_*
// rsp     | rsp_valid | rsp_ready | data_out_low data_out_high range_error
// csr     | csr_write_enable      | csr_index csr_write_data
// one beat per cycle while rsp is not stalled; 11 round stages, one output stage
// round keys ripple through registers after a key write, ahead of the beats, so the next beat already sees the new key
// synchronous reset empties the pipeline and clears the key
// a stalled rsp freezes every stage; nothing is dropped or repeated
module flash_aes_ctr_keystream_xor_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_block_address,
   input  logic [3:0]  req_byte_offset,
   input  logic [4:0]  req_byte_count,
   input  logic [63:0] req_data_in_low,
   input  logic [63:0] req_data_in_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_data_out_low,
   output logic [63:0] rsp_data_out_high,
   output logic        rsp_range_error,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);
   import fack_pkg::*;

   block_type round_keys [11];
   block_type ctr_block, ks;
   side_type  side_in, side_out;
   logic      pipe_valid, advance;
   logic      out_valid_ff;
   block_type out_data_ff, out_data_in;
   logic      out_err_ff;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   assign ctr_block = {req_block_address, Nonce};
   always_comb begin
      side_in.range_err = ({1'b0, req_byte_offset} + {1'b0, req_byte_count}) > 6'd16;
      side_in.offset    = req_byte_offset;
      side_in.count     = req_byte_count;
      side_in.data      = {req_data_in_high, req_data_in_low};
   end

   fack_key_sched u_keys (
      .clock, .reset, .csr_write_enable, .csr_index, .csr_write_data,
      .round_keys
   );

   fack_round_pipe u_pipe (
      .clock, .reset, .advance,
      .in_valid  (req_valid),
      .in_block  (ctr_block),
      .in_side   (side_in),
      .round_keys,
      .out_valid (pipe_valid),
      .out_block (ks),
      .out_side  (side_out)
   );

   // shift keystream down by offset bytes, xor into data, mask to count; zero on range error
   always_comb begin
      block_type rot;
      rot = ks >> {side_out.offset, 3'b000};
      for (int i = 0; i < NumBytes; i++) begin
         out_data_in[8*i +: 8] = (i < side_out.count && !side_out.range_err)
                                 ? side_out.data[8*i +: 8] ^ rot[8*i +: 8] : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= pipe_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
         out_err_ff  <= side_out.range_err;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_data_out_low  = out_data_ff[63:0];
   assign rsp_data_out_high = out_data_ff[127:64];
   assign rsp_range_error   = out_err_ff;

`ifndef NO_ASSERTIONS
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out_low)
                                  && $stable(rsp_range_error))
      else $error("rsp changed under stall");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_data_out_low == 64'd0
                                       && rsp_data_out_high == 64'd0)
      else $error("range error with data");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("ready mismatch");
`endif
endmodule

### tb/tb_flash_aes_ctr_keystream_xor_unit.sv
module tb_flash_aes_ctr_keystream_xor_unit;
   import fack_pkg::*;

   localparam logic [1:0] CsrSpare0 = 2'd2;
   localparam logic [1:0] CsrSpare1 = 2'd3;
   localparam int         CycleLimit = 400000;

   typedef struct {
      logic [31:0] addr;
      logic [3:0]  off;
      logic [4:0]  cnt;
      logic [63:0] src_lo;
      logic [63:0] src_hi;
   } access_type;

   typedef struct {
      logic [63:0] lo;
      logic [63:0] hi;
      logic        err;
   } xform_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [31:0] req_block_address = '0;
   logic [3:0]  req_byte_offset = '0;
   logic [4:0]  req_byte_count = '0;
   logic [63:0] req_data_in_low = '0;
   logic [63:0] req_data_in_high = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [63:0] rsp_data_out_low;
   logic [63:0] rsp_data_out_high;
   logic        rsp_range_error;
   logic        csr_write_enable = 0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_write_data = '0;

   access_type  pending_accesses[$];
   xform_type   expected_xforms[$];
   logic [7:0]  sub_table[256];
   logic [63:0] key_lo_m = '0;
   logic [63:0] key_hi_m = '0;
   logic        calm = 0;
   logic        hold_go = 0;
   int          hold_left = 0;
   int          errors = 0;
   int          cycles = 0;

   flash_aes_ctr_keystream_xor_unit dut (.*);

   always #5 clock = ~clock;

   function automatic logic [7:0] dbl(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = dbl(a);
      end
      return p;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
      return (v << n) | (v >> (8 - n));
   endfunction

   // sbox from the field inverse and the affine map
   function automatic void build_sub_table();
      logic [7:0] inv;
      for (int x = 0; x < 256; x++) begin
         inv = 0;
         for (int y = 1; y < 256; y++)
            if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         sub_table[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3)
                        ^ rotl8(inv, 4) ^ 8'h63;
      end
   endfunction

   function automatic logic [127:0] keystream_for(input logic [31:0] addr);
      logic [7:0]   rk[176];
      logic [7:0]   st[16];
      logic [7:0]   t[16];
      logic [7:0]   w0, w1, w2, w3, tmp, rc, all;
      logic [127:0] key, ks;
      key = {key_hi_m, key_lo_m};
      for (int i = 0; i < 16; i++) rk[i] = key[8*i +: 8];
      rc = 8'h01;
      for (int i = 16; i < 176; i += 4) begin
         w0 = rk[i-4]; w1 = rk[i-3]; w2 = rk[i-2]; w3 = rk[i-1];
         if (i % 16 == 0) begin
            tmp = w0;
            w0 = sub_table[w1] ^ rc;
            w1 = sub_table[w2];
            w2 = sub_table[w3];
            w3 = sub_table[tmp];
            rc = dbl(rc);
         end
         rk[i] = rk[i-16] ^ w0; rk[i+1] = rk[i-15] ^ w1;
         rk[i+2] = rk[i-14] ^ w2; rk[i+3] = rk[i-13] ^ w3;
      end
      for (int i = 0; i < 12; i++) st[i] = Nonce[8*i +: 8];
      for (int i = 0; i < 4; i++) st[12+i] = addr[8*i +: 8];
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
               t[i+4*c] = sub_table[st[i + 4*((c+i) % 4)]];
         if (r < 10) begin
            for (int c = 0; c < 4; c++) begin
               w0 = t[4*c]; w1 = t[4*c+1]; w2 = t[4*c+2]; w3 = t[4*c+3];
               all = w0 ^ w1 ^ w2 ^ w3;
               t[4*c]   = w0 ^ all ^ dbl(w0 ^ w1);
               t[4*c+1] = w1 ^ all ^ dbl(w1 ^ w2);
               t[4*c+2] = w2 ^ all ^ dbl(w2 ^ w3);
               t[4*c+3] = w3 ^ all ^ dbl(w3 ^ w0);
            end
         end
         for (int i = 0; i < 16; i++) st[i] = t[i] ^ rk[16*r + i];
      end
      for (int i = 0; i < 16; i++) ks[8*i +: 8] = st[i];
      return ks;
   endfunction

   function automatic xform_type predict_xform(input access_type a);
      xform_type    x;
      logic [127:0] ks, src, dst;
      dst = '0;
      x.err = (a.off + a.cnt > 16);
      if (!x.err) begin
         ks = keystream_for(a.addr);
         src = {a.src_hi, a.src_lo};
         for (int i = 0; i < 16; i++)
            if (i < a.cnt) dst[8*i +: 8] = src[8*i +: 8] ^ ks[8*((a.off + i) % 16) +: 8];
      end
      x.lo = dst[63:0];
      x.hi = dst[127:64];
      return x;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   function automatic logic want_idle();
      return !calm && ($urandom_range(0, 99) < 33);
   endfunction

   // driver
   always @(posedge clock) begin
      access_type a;
      if (!reset) begin
         if (req_valid && req_ready) begin
            a.addr = req_block_address; a.off = req_byte_offset; a.cnt = req_byte_count;
            a.src_lo = req_data_in_low; a.src_hi = req_data_in_high;
            expected_xforms.push_back(predict_xform(a));
         end
         if (!req_valid || req_ready) begin
            if (pending_accesses.size() > 0 && !want_idle()) begin
               a = pending_accesses.pop_front();
               req_valid <= 1;
               req_block_address <= a.addr;
               req_byte_offset <= a.off;
               req_byte_count <= a.cnt;
               req_data_in_low <= a.src_lo;
               req_data_in_high <= a.src_hi;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      xform_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_xforms.size() == 0) begin
               report_mismatch("unexpected beat", rsp_data_out_low, '0);
            end else begin
               e = expected_xforms.pop_front();
               if (rsp_data_out_low !== e.lo)
                  report_mismatch("data_out_low", rsp_data_out_low, e.lo);
               if (rsp_data_out_high !== e.hi)
                  report_mismatch("data_out_high", rsp_data_out_high, e.hi);
               if (rsp_range_error !== e.err)
                  report_mismatch("range_error", 64'(rsp_range_error), 64'(e.err));
            end
         end
         if (hold_go) hold_left <= 150;
         else if (hold_left > 0) hold_left <= hold_left - 1;
         rsp_ready <= !hold_go && hold_left <= 1 && !want_idle();
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("tb_flash_aes_ctr_keystream_xor_unit failed");
         $finish;
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      if (idx == CsrKeyLow) key_lo_m = val;
      else if (idx == CsrKeyHigh) key_hi_m = val;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic load_key(input logic [63:0] lo, input logic [63:0] hi);
      write_csr(CsrKeyLow, lo);
      write_csr(CsrKeyHigh, hi);
      write_csr($urandom_range(0, 1) ? CsrSpare0 : CsrSpare1, {$urandom, $urandom});
      // key expansion ripple
      repeat (14) @(posedge clock);
   endtask

   task automatic drain();
      while (pending_accesses.size() > 0 || req_valid || expected_xforms.size() > 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic add_access(input logic [31:0] addr, input int off, input int cnt,
                             input logic [63:0] lo, input logic [63:0] hi);
      access_type a;
      a.addr = addr; a.off = 4'(off); a.cnt = 5'(cnt); a.src_lo = lo; a.src_hi = hi;
      pending_accesses.push_back(a);
   endtask

   task automatic add_random(input int n);
      int off, cnt;
      for (int i = 0; i < n; i++) begin
         off = $urandom_range(0, 15);
         if ($urandom_range(0, 9) < 8) cnt = $urandom_range(0, 16 - off);
         else cnt = $urandom_range(0, 31);
         add_access($urandom, off, cnt, {$urandom, $urandom}, {$urandom, $urandom});
      end
   endtask

   initial begin
      build_sub_table();
      repeat (6) @(posedge clock);
      reset <= 0;
      // directed, under the reset key
      add_access(32'h0, 0, 16, '1, '1);
      add_access(32'hffff_ffff, 0, 16, '0, '0);
      add_access(32'h1234_5678, 15, 1, '1, '1);
      add_access(32'h0000_0001, 0, 0, '1, '1);
      add_access(32'h8000_0000, 15, 16, '1, '1);
      add_access(32'hdead_beef, 0, 17, '1, '1);
      add_access(32'h0bad_f00d, 0, 31, '1, '1);
      add_access(32'h5555_aaaa, 8, 8, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
      add_access(32'haaaa_5555, 1, 15, '1, '0);
      add_access(32'h7fff_ffff, 9, 8, '0, '1);
      calm = 1;
      add_random(60);
      drain();
      load_key('1, '1);
      add_random(80);
      calm = 0;
      add_random(60);
      drain();
      load_key({$urandom, $urandom}, {$urandom, $urandom});
      add_random(120);
      @(posedge clock);
      hold_go <= 1;
      @(posedge clock);
      hold_go <= 0;
      drain();
      load_key(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908);
      add_random(120);
      drain();
      load_key('0, '1);
      add_random(120);
      drain();
      load_key({$urandom, $urandom}, '0);
      add_random(120);
      drain();
      if (errors == 0) $display("tb_flash_aes_ctr_keystream_xor_unit passed");
      else $display("tb_flash_aes_ctr_keystream_xor_unit failed");
      $finish;
   end

endmodule

### flash_aes_ctr_keystream_xor_unit.f
design/fack_pkg.sv
design/fack_key_sched.sv
design/fack_round_pipe.sv
design/flash_aes_ctr_keystream_xor_unit.sv
tb/tb_flash_aes_ctr_keystream_xor_unit.sv
